[hw/rtl/lcd_mode_timing_defines.svh]
// Assertion macros used by the LCD mode timing top level.
`ifndef LCD_MODE_TIMING_DEFINES_SVH
`define LCD_MODE_TIMING_DEFINES_SVH

`ifndef SYNTHESIS
// Checked only outside reset.
`define LMT_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("lcd_mode_timing assertion failed");
// Checked on every edge, reset included.
`define LMT_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("lcd_mode_timing assertion failed");
`else
`define LMT_ASSERT(lbl, clk, rst, prop)
`define LMT_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

[hw/rtl/lcdmt_pkg.sv]
// Types and fixed constants of the LCD mode timing block.
package lcdmt_pkg;

  // Command codes
  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_CTRL   = 2'd1;
  localparam logic [1:0] CMD_STATUS = 2'd2;
  localparam logic [1:0] CMD_CMP    = 2'd3;

  // Status mode codes
  localparam logic [1:0] MODE_HBLANK = 2'd0;
  localparam logic [1:0] MODE_VBLANK = 2'd1;
  localparam logic [1:0] MODE_OAM    = 2'd2;
  localparam logic [1:0] MODE_DRAW   = 2'd3;

  // Register bit positions
  localparam int LCD_ON_BIT   = 7;
  localparam int CMP_FLAG_BIT = 2;
  localparam int HBL_EN_BIT   = 3;
  localparam int VBL_EN_BIT   = 4;
  localparam int OAM_EN_BIT   = 5;
  localparam int CMP_EN_BIT   = 6;

  localparam int ACC_W = 10;

  typedef struct packed {
    logic [1:0] command;
    logic [5:0] cycles;
    logic [7:0] write_data;
  } item_word_t;

  typedef struct packed {
    logic [7:0] line;
    logic [7:0] status;
    logic [7:0] control;
    logic       vblank_irq;
    logic       stat_irq;
    logic       oam_scan;
    logic       line_draw;
    logic       frame_start;
  } result_word_t;

  typedef struct packed {
    logic [7:0]       control;
    logic [7:0]       status;
    logic [7:0]       line;
    logic [7:0]       compare;
    logic [ACC_W-1:0] accum;
  } lcd_state_t;

endpackage

[hw/rtl/lcdmt_step.sv]
// Next-state and result logic for one word of the LCD mode sequencer.
module lcdmt_step #(
  parameter int OAM_CYCLES    = 80,
  parameter int DRAW_CYCLES   = 172,
  parameter int HBLANK_CYCLES = 204,
  parameter int LINE_CYCLES   = 456,
  parameter int VISIBLE_LINES = 144,
  parameter int BLANK_LINES   = 10
) (
  input  lcdmt_pkg::lcd_state_t   state,
  input  lcdmt_pkg::item_word_t   item,
  output lcdmt_pkg::lcd_state_t   state_next,
  output lcdmt_pkg::result_word_t result
);
  import lcdmt_pkg::*;

  localparam logic [ACC_W-1:0] OAM_LEN  = ACC_W'(OAM_CYCLES);
  localparam logic [ACC_W-1:0] DRAW_LEN = ACC_W'(DRAW_CYCLES);
  localparam logic [ACC_W-1:0] HBL_LEN  = ACC_W'(HBLANK_CYCLES);
  localparam logic [ACC_W-1:0] LINE_LEN = ACC_W'(LINE_CYCLES);
  localparam logic [7:0]       VIS_END  = 8'(VISIBLE_LINES);
  localparam logic [7:0]       LAST_LN  = 8'(VISIBLE_LINES + BLANK_LINES);

  lcd_state_t       nxt;
  logic [ACC_W-1:0] acc_sum;
  logic [7:0]       line_inc;
  logic             hit;
  logic             stat;
  logic             vbl;
  logic             oam;
  logic             draw;
  logic             frame;

  always_comb begin
    nxt      = state;
    acc_sum  = state.accum + ACC_W'(item.cycles);
    line_inc = state.line + 8'd1;
    hit      = 1'b0;
    stat     = 1'b0;
    vbl      = 1'b0;
    oam      = 1'b0;
    draw     = 1'b0;
    frame    = 1'b0;
    unique case (item.command)
      CMD_CTRL: begin
        if (state.control[LCD_ON_BIT] && !item.write_data[LCD_ON_BIT]) begin
          nxt.line        = '0;
          nxt.status[1:0] = MODE_HBLANK;
        end else if (!state.control[LCD_ON_BIT] && item.write_data[LCD_ON_BIT]) begin
          hit = (state.line == state.compare);
          nxt.status[CMP_FLAG_BIT] = hit;
          stat = hit && state.status[CMP_EN_BIT];
        end
        nxt.accum   = '0;
        nxt.control = item.write_data;
      end
      CMD_STATUS: begin
        // low three bits are read-only, bit 7 reads as one
        nxt.status = {1'b1, item.write_data[6:3], state.status[2:0]};
      end
      CMD_CMP: begin
        nxt.compare = item.write_data;
        hit = (state.line == item.write_data);
        nxt.status[CMP_FLAG_BIT] = hit;
        stat = hit && state.status[CMP_EN_BIT];
      end
      default: begin
        if (state.control[LCD_ON_BIT]) begin
          nxt.accum = acc_sum;
          unique case (state.status[1:0])
            MODE_OAM: begin
              if (acc_sum >= OAM_LEN) begin
                nxt.accum       = acc_sum - OAM_LEN;
                nxt.status[1:0] = MODE_DRAW;
                oam             = 1'b1;
              end
            end
            MODE_DRAW: begin
              if (acc_sum >= DRAW_LEN) begin
                nxt.accum       = acc_sum - DRAW_LEN;
                nxt.status[1:0] = MODE_HBLANK;
                stat            = state.status[HBL_EN_BIT];
                draw            = 1'b1;
              end
            end
            MODE_HBLANK: begin
              if (acc_sum >= HBL_LEN) begin
                nxt.accum = acc_sum - HBL_LEN;
                nxt.line  = line_inc;
                hit = (line_inc == state.compare);
                nxt.status[CMP_FLAG_BIT] = hit;
                if (line_inc < VIS_END) begin
                  nxt.status[1:0] = MODE_OAM;
                  stat = (hit && state.status[CMP_EN_BIT]) || state.status[OAM_EN_BIT];
                end else begin
                  nxt.status[1:0] = MODE_VBLANK;
                  vbl  = 1'b1;
                  stat = (hit && state.status[CMP_EN_BIT]) || state.status[VBL_EN_BIT];
                end
              end
            end
            default: begin
              // V-blank line ends strictly past the line length
              if (acc_sum > LINE_LEN) begin
                nxt.accum = acc_sum - LINE_LEN;
                if (state.line > LAST_LN) begin
                  nxt.line        = '0;
                  hit             = (state.compare == 8'd0);
                  nxt.status[1:0] = MODE_OAM;
                  frame           = 1'b1;
                end else begin
                  nxt.line = line_inc;
                  hit      = (line_inc == state.compare);
                end
                nxt.status[CMP_FLAG_BIT] = hit;
                stat = hit && state.status[CMP_EN_BIT];
              end
            end
          endcase
        end
      end
    endcase
  end

  assign state_next = nxt;

  always_comb begin
    result.line        = nxt.line;
    result.status      = nxt.status;
    result.control     = nxt.control;
    result.vblank_irq  = vbl;
    result.stat_irq    = stat;
    result.oam_scan    = oam;
    result.line_draw   = draw;
    result.frame_start = frame;
  end

endmodule

[hw/rtl/lcd_mode_timing.sv]
// Top level of the LCD controller mode sequencer.
//
// Usage notes:
// - item channel (item_valid / item_stall / item) carries one word per step:
//   a tick with elapsed machine cycles, or a write of control, status or
//   line compare. A word is taken on a clock edge with valid high, stall low.
// - result channel (result_valid / result_stall / result) returns exactly one
//   word per item word: line, status and control after the step plus the
//   interrupt and event pulses of that step.
// - Path: an accepted word is held in the input register, and its result is
//   then registered in the result register, from which it is offered.
// - Throughput: one word per cycle while result_stall is low. The recurrence
//   through the state registers (mode, line, accumulator) sets that rate.
// - Stall: when result_stall holds a pending result, the input register
//   fills and item_stall rises; nothing is dropped or repeated.
// - Reset (rst, synchronous): all state registers clear (display off,
//   mode 0, line 0), both pipeline stages empty.
`include "lcd_mode_timing_defines.svh"

module lcd_mode_timing #(
  parameter int OAM_CYCLES    = 80,
  parameter int DRAW_CYCLES   = 172,
  parameter int HBLANK_CYCLES = 204,
  parameter int LINE_CYCLES   = 456,
  parameter int VISIBLE_LINES = 144,
  parameter int BLANK_LINES   = 10
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    item_valid,
  output logic                    item_stall,
  input  lcdmt_pkg::item_word_t   item,
  output logic                    result_valid,
  input  logic                    result_stall,
  output lcdmt_pkg::result_word_t result
);
  import lcdmt_pkg::*;

  // Input register stage
  logic         item_q_valid;
  item_word_t   item_q;

  // Architectural state of the sequencer
  lcd_state_t   state;
  lcd_state_t   state_next;
  result_word_t result_next;

  logic out_free;
  logic fire;
  logic accept;

  // Result slot can load when empty or being drained this cycle.
  assign out_free   = !result_valid || !result_stall;
  assign fire       = item_q_valid && out_free;
  assign item_stall = item_q_valid && !out_free;
  assign accept     = item_valid && !item_stall;

  lcdmt_step #(
    .OAM_CYCLES   (OAM_CYCLES),
    .DRAW_CYCLES  (DRAW_CYCLES),
    .HBLANK_CYCLES(HBLANK_CYCLES),
    .LINE_CYCLES  (LINE_CYCLES),
    .VISIBLE_LINES(VISIBLE_LINES),
    .BLANK_LINES  (BLANK_LINES)
  ) u_step (
    .state     (state),
    .item      (item_q),
    .state_next(state_next),
    .result    (result_next)
  );

  // Control: stage valids and sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
      result_valid <= 1'b0;
      state        <= '0;
    end else begin
      if (accept) begin
        item_q_valid <= 1'b1;
      end else if (fire) begin
        item_q_valid <= 1'b0;
      end
      result_valid <= fire || (result_valid && result_stall);
      if (fire) begin
        state <= state_next;
      end
    end
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      item_q <= item;
    end
    if (fire) begin
      result <= result_next;
    end
  end

  // Display off: a tick leaves line and status untouched.
  `LMT_ASSERT(a_off_tick_idle, clk, rst,
    (fire && item_q.command == CMD_TICK && !state.control[LCD_ON_BIT])
      |=> ($stable(state.line) && $stable(state.status)))
  // Event pulses of one step never coincide.
  `LMT_ASSERT(a_events_exclusive, clk, rst,
    result_valid |-> $onehot0({result.vblank_irq, result.oam_scan,
                               result.line_draw, result.frame_start}))
  // Status bit 7, once written, stays until reset.
  `LMT_ASSERT(a_status_top_sticky, clk, rst,
    state.status[7] |=> state.status[7])
  // Input is held off only while the input register is occupied.
  `LMT_ASSERT(a_stall_only_full, clk, rst,
    item_stall |-> item_q_valid)
  // Reset leaves the display off at line zero with both stages empty.
  `LMT_ASSERT_ALWAYS(a_reset_clears, clk,
    rst |=> (state == '0 && !item_q_valid && !result_valid))

endmodule
